>>> hw/rtl/word_definition_record_scanner_assert.svh
// Assertion macros shared by the record scanner RTL.
// Users must have clk and rst_n in scope where a macro is used.
`ifndef WORD_DEFINITION_RECORD_SCANNER_ASSERT_SVH
`define WORD_DEFINITION_RECORD_SCANNER_ASSERT_SVH

// Checked only while the block is out of reset.
`define WDRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WDRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/wdrs_pkg.sv
// Package for the word definition record scanner: payload types, codes and constants.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package wdrs_pkg;

  typedef enum logic [1:0] {
    ST_ACCEPTED      = 2'd0,
    ST_EMPTY_WORD    = 2'd1,
    ST_WORD_TOO_LONG = 2'd2,
    ST_NO_RECORD     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [31:0] record_offset;
    logic [5:0]  word_length;
    logic [31:0] def_length;
    status_t     status;
    logic        stream_end;
  } out_item_t;

  // Results produced by one input byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
  } scan_res_t;

  localparam logic [5:0] WORD_LEN_RESET = 6'd60;
  localparam logic [5:0] WORD_SAT       = 6'd63;
  localparam logic [7:0] CH_AT          = 8'h40;
  localparam logic [7:0] CH_NL          = 8'h0A;
  localparam logic [7:0] CH_SP          = 8'h20;
  localparam int         RES_DEPTH      = 4;

endpackage

`default_nettype wire

>>> hw/rtl/wdrs_scan.sv
// Record scanner state and per-byte result logic.
// Depends on wdrs_pkg and word_definition_record_scanner_assert.svh.
`default_nettype none
`include "word_definition_record_scanner_assert.svh"

module wdrs_scan
  import wdrs_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire in_item_t    item,
  input  wire logic [5:0]  max_word_length,
  output scan_res_t        res
);

  localparam int EXT_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
  localparam logic [OFFSET_BITS-1:0] DC_MAX = '1;

  logic [OFFSET_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic                   prev_nl_r, prev_nl_nxt;
  logic                   in_record_r, in_record_nxt;
  logic                   sep_r, sep_nxt;
  logic [OFFSET_BITS-1:0] rec_start_r, rec_start_nxt;
  logic [5:0]             word_cnt_r, word_cnt_nxt;
  logic [OFFSET_BITS-1:0] def_cnt_r, def_cnt_nxt;

  function automatic logic [31:0] ext32(input logic [OFFSET_BITS-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[31:0];
  endfunction

  function automatic out_item_t make_rec(input logic [OFFSET_BITS-1:0] rs,
                                         input logic [5:0] wc,
                                         input logic [OFFSET_BITS-1:0] dc,
                                         input logic fin,
                                         input logic [5:0] mwl);
    out_item_t r;
    r.record_offset = ext32(rs);
    r.word_length   = wc;
    r.def_length    = ext32(dc);
    r.stream_end    = fin;
    if (wc == 6'd0) begin
      r.status = ST_EMPTY_WORD;
    end else if (wc == WORD_SAT || wc > mwl) begin
      r.status = ST_WORD_TOO_LONG;
    end else begin
      r.status = ST_ACCEPTED;
    end
    return r;
  endfunction

  logic      is_nl;
  logic      marker;
  logic      closing;
  out_item_t close_res;
  out_item_t eof_res;

  always_comb begin
    is_nl   = (item.data_byte == CH_NL);
    marker  = prev_nl_r && (item.data_byte == CH_AT);
    closing = in_record_r && marker;

    in_record_nxt = in_record_r;
    sep_nxt       = sep_r;
    rec_start_nxt = rec_start_r;
    word_cnt_nxt  = word_cnt_r;
    def_cnt_nxt   = def_cnt_r;

    close_res = make_rec(rec_start_r, word_cnt_r, def_cnt_r, 1'b0, max_word_length);

    if (marker) begin
      in_record_nxt = 1'b1;
      sep_nxt       = 1'b0;
      rec_start_nxt = byte_pos_r + OFFSET_BITS'(1);
      word_cnt_nxt  = 6'd0;
      def_cnt_nxt   = '0;
    end else if (in_record_r) begin
      // A held-back newline turns out to be record content.
      if (prev_nl_r) begin
        if (!sep_nxt) begin
          sep_nxt = 1'b1;
        end else if (def_cnt_nxt != DC_MAX) begin
          def_cnt_nxt = def_cnt_nxt + OFFSET_BITS'(1);
        end
      end
      if (!is_nl || item.end_of_file) begin
        if (!sep_nxt) begin
          if (item.data_byte == CH_SP || is_nl) begin
            sep_nxt = 1'b1;
          end else if (word_cnt_nxt != WORD_SAT) begin
            word_cnt_nxt = word_cnt_nxt + 6'd1;
          end
        end else if (def_cnt_nxt != DC_MAX) begin
          def_cnt_nxt = def_cnt_nxt + OFFSET_BITS'(1);
        end
      end
    end

    if (in_record_nxt) begin
      eof_res = make_rec(rec_start_nxt, word_cnt_nxt, def_cnt_nxt, 1'b1, max_word_length);
    end else begin
      eof_res.record_offset = 32'd0;
      eof_res.word_length   = 6'd0;
      eof_res.def_length    = 32'd0;
      eof_res.status        = ST_NO_RECORD;
      eof_res.stream_end    = 1'b1;
    end

    res.res0 = closing ? close_res : eof_res;
    res.res1 = eof_res;
    if (closing && item.end_of_file) begin
      res.count = 2'd2;
    end else if (closing || item.end_of_file) begin
      res.count = 2'd1;
    end else begin
      res.count = 2'd0;
    end

    prev_nl_nxt  = is_nl;
    byte_pos_nxt = byte_pos_r + OFFSET_BITS'(1);

    // The end of the file returns the stream state to its reset values.
    if (item.end_of_file) begin
      prev_nl_nxt   = 1'b1;
      byte_pos_nxt  = '0;
      in_record_nxt = 1'b0;
      sep_nxt       = 1'b0;
      rec_start_nxt = '0;
      word_cnt_nxt  = 6'd0;
      def_cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      prev_nl_r   <= 1'b1;
      in_record_r <= 1'b0;
      sep_r       <= 1'b0;
      rec_start_r <= '0;
      word_cnt_r  <= 6'd0;
      def_cnt_r   <= '0;
    end else if (step) begin
      byte_pos_r  <= byte_pos_nxt;
      prev_nl_r   <= prev_nl_nxt;
      in_record_r <= in_record_nxt;
      sep_r       <= sep_nxt;
      rec_start_r <= rec_start_nxt;
      word_cnt_r  <= word_cnt_nxt;
      def_cnt_r   <= def_cnt_nxt;
    end
  end

  `WDRS_ASSERT(a_eof_clears, step && item.end_of_file |=> byte_pos_r == '0 && !in_record_r && prev_nl_r, "end of file did not clear the stream state")
  `WDRS_ASSERT(a_two_results_order, res.count == 2'd2 |-> res.res1.stream_end && !res.res0.stream_end, "second result must be the final one")

endmodule

`default_nettype wire

>>> hw/rtl/wdrs_rfifo.sv
// Small result queue that takes up to two results per cycle and delivers one while out_ready is high.
// Depends on wdrs_pkg and word_definition_record_scanner_assert.svh.
`default_nettype none
`include "word_definition_record_scanner_assert.svh"

module wdrs_rfifo
  import wdrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire scan_res_t push_res,
  output logic           room2,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  out_item_t              mem [RES_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [1:0]             push_n;
  logic                   pop;

  always_comb begin
    push_n     = push ? push_res.count : 2'd0;
    pop        = out_valid && out_ready;
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_n) - CNT_W'(pop);
  end

  assign room2     = (count_r <= CNT_W'(RES_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push_res.res0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push_res.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `WDRS_ASSERT(a_no_overflow, push_n != 2'd0 |-> room2, "result queue written without room")
  `WDRS_ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= CNT_W'(RES_DEPTH), "result queue count out of range")
  `WDRS_ASSERT(a_ptr_track, wr_ptr_r == rd_ptr_r + PTR_W'(count_r), "result queue pointers disagree with count")

endmodule

`default_nettype wire

>>> hw/rtl/word_definition_record_scanner.sv
// Top level of the word definition record scanner.
// Depends on wdrs_pkg, wdrs_scan and wdrs_rfifo.
//
// Usage:
// The input channel (in_valid, in_ready, in_item) carries one file byte per
// transaction, with end_of_file set on the final byte. The result channel
// (out_valid, out_ready, out_item) carries one record result per transaction.
// A byte yields no result, one result, or two results when a newline-'@'
// pair that closes a record ends the file. The configuration channel
// (cfg_valid, cfg_ready, cfg_wdata) writes the maximum word length and is
// always ready; write it only while no byte is in flight.
// A result passes through the input register and then the result queue
// before it is offered.
// Throughput: one byte per cycle, set by the single registered pass from the
// input register into the four-entry result queue; a byte moves on when the
// queue has room for two results.
// Reset (rst_n low, synchronous) empties both registers, restarts the stream
// at offset 0 and sets the maximum word length to 60. When the receiver
// stalls, results wait in the queue; in_ready drops when two will not fit.
`default_nettype none

module word_definition_record_scanner
  import wdrs_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_wdata
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic [5:0] max_word_length_r;
  logic       room2;
  logic       step;
  scan_res_t  scan_res;

  assign step      = in_valid_r && room2;
  assign in_ready  = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      max_word_length_r <= WORD_LEN_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (cfg_valid && cfg_ready) begin
        max_word_length_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  wdrs_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .item            (in_item_r),
    .max_word_length (max_word_length_r),
    .res             (scan_res)
  );

  wdrs_rfifo u_rfifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_res  (scan_res),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
